[hw/rtl/mpc_pkg.sv]
// Shared constants, types and width helpers for the masked Pearson correlation unit.
package mpc_pkg;

	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int LIMIT_W = 24;
	localparam int LEAST_W = 13;
	localparam int ROW_W = 16;
	localparam int CORR_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RATIO_SHIFT = 60;
	localparam int QUOT_W = 62;
	localparam int ONE_Q30 = 1073741824;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAST_SAMPLES = 2'd2;

	typedef logic signed [LIMIT_W-1:0] limit_t;
	typedef logic [LEAST_W-1:0] least_t;
	typedef logic [ROW_W-1:0] row_t;

	localparam limit_t LOW_LIMIT_RST = 24'sd0;
	localparam limit_t HIGH_LIMIT_RST = 24'sd1310720;
	localparam least_t LEAST_SAMPLES_RST = 13'd30;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int cnt_width(input int max_samples);
		return $clog2(max_samples + 1);
	endfunction

	function automatic int sx_width(input int sample_bits, input int max_samples);
		return min_int(64, sample_bits + cnt_width(max_samples));
	endfunction

	function automatic int sq_width(input int sample_bits, input int max_samples);
		return min_int(64, 2 * sample_bits + cnt_width(max_samples));
	endfunction

	function automatic int num_width(input int sample_bits, input int max_samples);
		return max_int(cnt_width(max_samples) + 1 + sq_width(sample_bits, max_samples),
			2 * sx_width(sample_bits, max_samples)) + 1;
	endfunction

	function automatic int entry_width(input int sample_bits, input int max_samples);
		return 2 * ROW_W + cnt_width(max_samples) + 2 * sx_width(sample_bits, max_samples)
			+ 3 * sq_width(sample_bits, max_samples);
	endfunction

endpackage

[hw/rtl/masked_pearson_correlation_unit.sv]
// Top level of the masked Pearson correlation unit.
// Sample pairs are taken at one per cycle; screening and accumulation run in a three-stage
// front pipeline. When the pair marked last has been added, its sums go into a four-entry
// queue and the back end works on them alone: up to eight shift-and-add multiplies of
// num_width bits each, a 63-step restoring division and a 31-step square root. Input
// stalls while the row pairs queued or still in the front pipeline number four.
// Configuration writes must be made while the block is idle.
module masked_pearson_correlation_unit import mpc_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] x_value,
	input  logic                          x_missing,
	input  logic signed [SAMPLE_BITS-1:0] y_value,
	input  logic                          y_missing,
	input  row_t                          row_a,
	input  row_t                          row_b,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output row_t                          pair_first,
	output row_t                          pair_second,
	output logic signed [CORR_W-1:0]      correlation,
	output least_t                        used_samples
);
	localparam int ENTRY_W = entry_width(SAMPLE_BITS, MAX_SAMPLES);

	limit_t low_q, high_q;
	least_t least_q;
	logic push, pop, empty;
	logic [ENTRY_W-1:0] push_data, pop_data;
	logic [QUEUE_LVL_W-1:0] level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= LOW_LIMIT_RST;
			high_q <= HIGH_LIMIT_RST;
			least_q <= LEAST_SAMPLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_LIMIT: low_q <= cfg_data;
				REG_HIGH_LIMIT: high_q <= cfg_data;
				REG_LEAST_SAMPLES: least_q <= cfg_data[LEAST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mpc_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_value(x_value),
		.x_missing(x_missing),
		.y_value(y_value),
		.y_missing(y_missing),
		.row_a(row_a),
		.row_b(row_b),
		.last(last),
		.low_limit(low_q),
		.high_limit(high_q),
		.level(level),
		.push(push),
		.push_data(push_data)
	);

	mpc_fifo #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty),
		.level(level)
	);

	mpc_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop(pop),
		.pop_data(pop_data),
		.least_samples(least_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pair_first(pair_first),
		.pair_second(pair_second),
		.correlation(correlation),
		.used_samples(used_samples)
	);
endmodule

[hw/rtl/mpc_fifo.sv]
// Short queue of finished row-pair sums between the front and back ends.
module mpc_fifo import mpc_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty,
	output logic [QUEUE_LVL_W-1:0] level
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [QUEUE_LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign pop_data = mem_q[rp_q];
	assign empty = (level_q == '0);
	assign level = level_q;
endmodule

[hw/rtl/mpc_front.sv]
// Front end: takes sample pairs, screens them and accumulates the running sums.
module mpc_front import mpc_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int ENTRY_W = entry_width(SAMPLE_BITS, MAX_SAMPLES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] x_value,
	input  logic                          x_missing,
	input  logic signed [SAMPLE_BITS-1:0] y_value,
	input  logic                          y_missing,
	input  row_t                          row_a,
	input  row_t                          row_b,
	input  logic                          last,
	input  limit_t                        low_limit,
	input  limit_t                        high_limit,
	input  logic [QUEUE_LVL_W-1:0]        level,
	output logic                          push,
	output logic [ENTRY_W-1:0]            push_data
);
	localparam int CW = cnt_width(MAX_SAMPLES);
	localparam int SX_W = sx_width(SAMPLE_BITS, MAX_SAMPLES);
	localparam int SQ_W = sq_width(SAMPLE_BITS, MAX_SAMPLES);
	localparam int CMP_W = max_int(SAMPLE_BITS, LIMIT_W);
	localparam int PR_W = 2 * SAMPLE_BITS;

	logic signed [CMP_W-1:0] x_c, y_c, lo_c, hi_c;
	logic [QUEUE_LVL_W:0] pending;
	logic accept, ok, take;
	logic [CW-1:0] cnt_q, n_now;

	logic vld_s1, take_s1, last_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1;
	logic [CW-1:0] n_s1;
	row_t ra_s1, rb_s1;

	logic vld_s2, take_s2, last_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2, y_s2;
	logic signed [PR_W-1:0] xx_s2, yy_s2, xy_s2;
	logic [CW-1:0] n_s2;
	row_t ra_s2, rb_s2;

	logic signed [SX_W-1:0] sx_q, sy_q, sx_next, sy_next;
	logic signed [SQ_W-1:0] sxx_q, syy_q, sxy_q, sxx_next, syy_next, sxy_next;

	assign pending = {1'b0, level} + (QUEUE_LVL_W + 1)'(vld_s1 & last_s1)
		+ (QUEUE_LVL_W + 1)'(vld_s2 & last_s2);
	assign in_stall = (pending >= (QUEUE_LVL_W + 1)'(QUEUE_DEPTH));
	assign accept = in_valid && !in_stall;

	assign x_c = CMP_W'(x_value);
	assign y_c = CMP_W'(y_value);
	assign lo_c = CMP_W'(low_limit);
	assign hi_c = CMP_W'(high_limit);
	assign ok = !x_missing && !y_missing && (lo_c < x_c) && (x_c < hi_c)
		&& (lo_c < y_c) && (y_c < hi_c);
	assign take = ok && (cnt_q < CW'(MAX_SAMPLES));
	assign n_now = take ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= last ? '0 : n_now;
			end
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_value;
		y_s1 <= y_value;
		take_s1 <= take;
		last_s1 <= last;
		n_s1 <= n_now;
		ra_s1 <= row_a;
		rb_s1 <= row_b;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		xy_s2 <= x_s1 * y_s1;
		take_s2 <= take_s1;
		last_s2 <= last_s1;
		n_s2 <= n_s1;
		ra_s2 <= ra_s1;
		rb_s2 <= rb_s1;
	end

	assign sx_next = sx_q + (take_s2 ? SX_W'(x_s2) : '0);
	assign sy_next = sy_q + (take_s2 ? SX_W'(y_s2) : '0);
	assign sxx_next = sxx_q + (take_s2 ? SQ_W'(xx_s2) : '0);
	assign syy_next = syy_q + (take_s2 ? SQ_W'(yy_s2) : '0);
	assign sxy_next = sxy_q + (take_s2 ? SQ_W'(xy_s2) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (vld_s2) begin
			if (last_s2) begin
				sx_q <= '0;
				sy_q <= '0;
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
			end else begin
				sx_q <= sx_next;
				sy_q <= sy_next;
				sxx_q <= sxx_next;
				syy_q <= syy_next;
				sxy_q <= sxy_next;
			end
		end
	end

	assign push = vld_s2 && last_s2;
	assign push_data = {ra_s2, rb_s2, n_s2, sx_next, sy_next, sxx_next, syy_next, sxy_next};
endmodule

[hw/rtl/mpc_mul.sv]
// Shift-and-add signed multiplier that retires one multiplier bit per cycle.
module mpc_mul import mpc_pkg::*; #(
	parameter int W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic                  done,
	output logic signed [2*W-1:0] p
);
	localparam int CNT_W = max_int($clog2(W), 1);

	logic busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0] ma_q;
	logic [2*W:0] prod_q;
	logic [W:0] sum;

	assign sum = prod_q[2*W:W] + (prod_q[0] ? {1'b0, ma_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[W-1] ? W'(-a) : W'(a);
			prod_q <= {{(W+1){1'b0}}, (b[W-1] ? W'(-b) : W'(b))};
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			prod_q <= {1'b0, sum, prod_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign p = neg_q ? -$signed(prod_q[2*W-1:0]) : $signed(prod_q[2*W-1:0]);
endmodule

[hw/rtl/mpc_back.sv]
// Back end: forms the variances and covariance, then divides and takes the root.
module mpc_back import mpc_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int ENTRY_W = entry_width(SAMPLE_BITS, MAX_SAMPLES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     empty,
	output logic                     pop,
	input  logic [ENTRY_W-1:0]       pop_data,
	input  least_t                   least_samples,
	output logic                     out_valid,
	input  logic                     out_stall,
	output row_t                     pair_first,
	output row_t                     pair_second,
	output logic signed [CORR_W-1:0] correlation,
	output least_t                   used_samples
);
	localparam int CW = cnt_width(MAX_SAMPLES);
	localparam int SX_W = sx_width(SAMPLE_BITS, MAX_SAMPLES);
	localparam int SQ_W = sq_width(SAMPLE_BITS, MAX_SAMPLES);
	localparam int MW = num_width(SAMPLE_BITS, MAX_SAMPLES);
	localparam int PW = 2 * MW;
	localparam int RW = PW + RATIO_SHIFT;
	localparam int DW = PW + QUOT_W;
	localparam int CMPN = max_int(CW, LEAST_W);
	localparam int DCNT_W = $clog2(QUOT_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL_GO = 3'd1;
	localparam logic [2:0] ST_MUL_WAIT = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	localparam logic [2:0] OP_N_XY = 3'd0;
	localparam logic [2:0] OP_X_Y = 3'd1;
	localparam logic [2:0] OP_N_XX = 3'd2;
	localparam logic [2:0] OP_X_X = 3'd3;
	localparam logic [2:0] OP_N_YY = 3'd4;
	localparam logic [2:0] OP_Y_Y = 3'd5;
	localparam logic [2:0] OP_NUM_SQ = 3'd6;
	localparam logic [2:0] OP_VX_VY = 3'd7;

	row_t ra_w, rb_w, ra_q, rb_q;
	logic [CW-1:0] n_w, n_q;
	logic signed [SX_W-1:0] sx_w, sy_w, sx_q, sy_q;
	logic signed [SQ_W-1:0] sxx_w, syy_w, sxy_w, sxx_q, syy_q, sxy_q;

	logic [2:0] state_q, op_q;
	logic signed [MW-1:0] mul_a, mul_b, n_ext;
	logic mul_start, mul_done;
	logic signed [PW-1:0] mul_p, t_q;
	logic signed [MW-1:0] num_q, vx_q, vy_q, diff;
	logic go;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] dv_q;
	logic ge, first_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [QUOT_W-1:0] quot_q, res_q, one_q, trial;
	logic [CORR_W-1:0] q_mag;
	logic out_valid_q, can_write;

	assign {ra_w, rb_w, n_w, sx_w, sy_w, sxx_w, syy_w, sxy_w} = pop_data;
	assign pop = (state_q == ST_IDLE) && !empty;
	assign n_ext = MW'(n_q);

	always_comb begin
		unique case (op_q)
			OP_N_XY: begin
				mul_a = n_ext;
				mul_b = MW'(sxy_q);
			end
			OP_X_Y: begin
				mul_a = MW'(sx_q);
				mul_b = MW'(sy_q);
			end
			OP_N_XX: begin
				mul_a = n_ext;
				mul_b = MW'(sxx_q);
			end
			OP_X_X: begin
				mul_a = MW'(sx_q);
				mul_b = MW'(sx_q);
			end
			OP_N_YY: begin
				mul_a = n_ext;
				mul_b = MW'(syy_q);
			end
			OP_Y_Y: begin
				mul_a = MW'(sy_q);
				mul_b = MW'(sy_q);
			end
			OP_NUM_SQ: begin
				mul_a = num_q;
				mul_b = num_q;
			end
			default: begin
				mul_a = vx_q;
				mul_b = vy_q;
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL_GO);

	mpc_mul #(.W(MW)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.p(mul_p)
	);

	assign diff = MW'(t_q - mul_p);
	assign go = (CMPN'(n_q) >= CMPN'(least_samples)) && !vx_q[MW-1] && (vx_q != '0)
		&& !diff[MW-1] && (diff != '0);
	assign ge = (DW'(rem_q) >= dv_q);
	assign trial = res_q + one_q;
	assign q_mag = (res_q > QUOT_W'(ONE_Q30)) ? CORR_W'(ONE_Q30) : CORR_W'(res_q);
	assign can_write = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_N_XY;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && can_write) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						op_q <= OP_N_XY;
						state_q <= ST_MUL_GO;
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (mul_done) begin
						if (op_q == OP_Y_Y && !go) begin
							state_q <= ST_IDLE;
						end else if (op_q == OP_VX_VY) begin
							state_q <= ST_DIV;
						end else begin
							op_q <= op_q + 1'b1;
							state_q <= ST_MUL_GO;
						end
					end
				end
				ST_DIV: begin
					if ((first_q && ge) || (!first_q && dcnt_q == '0)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (one_q[0]) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (can_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ra_q <= ra_w;
			rb_q <= rb_w;
			n_q <= n_w;
			sx_q <= sx_w;
			sy_q <= sy_w;
			sxx_q <= sxx_w;
			syy_q <= syy_w;
			sxy_q <= sxy_w;
		end
		if (state_q == ST_MUL_WAIT && mul_done) begin
			unique case (op_q)
				OP_N_XY, OP_N_XX, OP_N_YY: t_q <= mul_p;
				OP_X_Y: num_q <= diff;
				OP_X_X: vx_q <= diff;
				OP_Y_Y: vy_q <= diff;
				OP_NUM_SQ: rem_q <= {mul_p, {RATIO_SHIFT{1'b0}}};
				default: begin
					dv_q <= {mul_p, {QUOT_W{1'b0}}};
					first_q <= 1'b1;
					quot_q <= '0;
				end
			endcase
		end
		if (state_q == ST_DIV) begin
			if (first_q) begin
				if (ge) begin
					quot_q <= '1;
				end
				first_q <= 1'b0;
				dcnt_q <= DCNT_W'(QUOT_W - 1);
			end else begin
				if (ge) begin
					rem_q <= RW'(DW'(rem_q) - dv_q);
				end
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				dcnt_q <= dcnt_q - 1'b1;
			end
			dv_q <= dv_q >> 1;
			res_q <= '0;
			one_q <= QUOT_W'(1) << (QUOT_W - 2);
		end
		if (state_q == ST_SQRT) begin
			if (quot_q >= trial) begin
				quot_q <= quot_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
		if (state_q == ST_OUT && can_write) begin
			pair_first <= ra_q;
			pair_second <= rb_q;
			used_samples <= LEAST_W'(n_q);
			correlation <= num_q[MW-1] ? -$signed(q_mag) : $signed(q_mag);
		end
	end

	assign out_valid = out_valid_q;
endmodule

[test/testbench.sv]
// Self-checking testbench for the masked Pearson correlation unit: directed and random requests.
module testbench;
	import mpc_pkg::*;

	typedef struct {
		row_t               first;
		row_t               second;
		logic signed [31:0] corr;
		least_t             count;
	} corr_result_t;

	typedef struct {
		int   x;
		bit   xm;
		int   y;
		bit   ym;
		int   ra;
		int   rb;
		bit   lst;
		int   kind;
		int   corr;
	} stim_row_t;

	localparam int EXP_MODEL = 0;
	localparam int EXP_NONE  = 1;
	localparam int EXP_CORR  = 2;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [23:0] x_value;
	logic x_missing;
	logic signed [23:0] y_value;
	logic y_missing;
	row_t row_a;
	row_t row_b;
	logic last;
	logic out_valid;
	logic out_stall;
	row_t pair_first;
	row_t pair_second;
	logic signed [CORR_W-1:0] correlation;
	least_t used_samples;

	masked_pearson_correlation_unit u_dut (.*);

	always #5 clk = ~clk;

	longint lim_lo, lim_hi, min_count;
	longint n_pairs;
	logic signed [63:0] s_x, s_y, s_xx, s_yy, s_xy;
	corr_result_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int sender_idle = 27;
	int receiver_idle = 86;

	task automatic correlate_pair(input longint x, input bit xm, input longint y, input bit ym,
		input int ra, input int rb, input bit lst, output bit has, output corr_result_t r);
		logic signed [255:0] n, sx, sy, num, vx, vy, lhs, rhs, c;
		longint q;
		has = 1'b0;
		if (!xm && !ym && lim_lo < x && x < lim_hi && lim_lo < y && y < lim_hi &&
			n_pairs < MAX_SAMPLES_DEF) begin
			s_x += x;
			s_y += y;
			s_xx += x * x;
			s_yy += y * y;
			s_xy += x * y;
			n_pairs++;
		end
		if (lst) begin
			n = n_pairs;
			sx = s_x;
			sy = s_y;
			num = n * 256'(s_xy) - sx * sy;
			vx = n * 256'(s_xx) - sx * sx;
			vy = n * 256'(s_yy) - sy * sy;
			if (n_pairs >= min_count && vx > 0 && vy > 0) begin
				lhs = vx * vy;
				rhs = (num * num) <<< 60;
				q = 0;
				for (int b = 30; b >= 0; b--) begin
					c = q | (64'd1 << b);
					if (c * c * lhs <= rhs) q = longint'(c);
				end
				if (q > ONE_Q30) q = ONE_Q30;
				r.first = row_t'(ra);
				r.second = row_t'(rb);
				r.corr = 32'((num < 0) ? -q : q);
				r.count = least_t'(n_pairs);
				has = 1'b1;
			end
			n_pairs = 0;
			s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0;
		end
	endtask

	task automatic write_limits(input longint lo, input longint hi, input longint least);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_LOW_LIMIT;
		cfg_data <= CFG_DATA_W'(lo);
		@(posedge clk);
		cfg_index <= REG_HIGH_LIMIT;
		cfg_data <= CFG_DATA_W'(hi);
		@(posedge clk);
		cfg_index <= REG_LEAST_SAMPLES;
		cfg_data <= CFG_DATA_W'(least);
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_lo = lo;
		lim_hi = hi;
		min_count = least;
	endtask

	task automatic send_pair(input stim_row_t s);
		bit has;
		corr_result_t r;
		if (items_sent == 700) begin
			sender_idle = 86;
			receiver_idle = 27;
		end else if (items_sent == 1400) begin
			sender_idle = 0;
			receiver_idle = 0;
		end
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= 24'(s.x);
		x_missing <= s.xm;
		y_value <= 24'(s.y);
		y_missing <= s.ym;
		row_a <= row_t'(s.ra);
		row_b <= row_t'(s.rb);
		last <= s.lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		correlate_pair(s.x, s.xm, s.y, s.ym, s.ra, s.rb, s.lst, has, r);
		if (s.kind == EXP_NONE && has)
			$display("%0t: expected no result for rows %0d/%0d, model gives one",
				$time, s.ra, s.rb);
		if (s.kind == EXP_CORR && (!has || r.corr != s.corr)) begin
			$display("%0t: expected correlation %0d, model gives %0d", $time, s.corr, r.corr);
			errors++;
		end
		if (s.kind == EXP_NONE && has) errors++;
		if (has) pending_results = {pending_results, r};
	endtask

	function automatic int pick(input longint lo, input longint hi);
		return int'(lo + 1 + longint'($urandom) % (hi - lo - 1));
	endfunction

	task automatic send_row(input int len, input int noise);
		stim_row_t s;
		int ra, rb, mode;
		ra = $urandom_range(65535);
		rb = $urandom_range(65535);
		mode = $urandom_range(3);
		for (int i = 0; i < len; i++) begin
			s.x = pick(lim_lo, lim_hi);
			case (mode)
				0: s.y = pick(lim_lo, lim_hi);
				1: s.y = s.x;
				2: s.y = int'(lim_lo + lim_hi - s.x);
				default: begin
					s.y = s.x + $signed($urandom_range(4000)) - 2000;
					if (s.y <= lim_lo || s.y >= lim_hi) s.y = s.x;
				end
			endcase
			s.xm = 1'b0;
			s.ym = 1'b0;
			if ($urandom_range(99) < noise) begin
				s.xm = $urandom_range(3) == 0;
				s.ym = $urandom_range(3) == 0;
				if ($urandom_range(1)) s.x = $signed(24'($urandom));
				if ($urandom_range(1)) s.y = $signed(24'($urandom));
			end
			s.ra = ra;
			s.rb = rb;
			s.lst = (i == len - 1);
			s.kind = EXP_MODEL;
			send_pair(s);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle);
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: rows %0d/%0d corr %0d", $time,
					pair_first, pair_second, correlation);
				errors++;
			end else begin
				corr_result_t e;
				e = pending_results.pop_front();
				if (pair_first !== e.first || pair_second !== e.second ||
					correlation !== e.corr || used_samples !== e.count) begin
					$display("%0t: expected rows %0d/%0d corr %0d n %0d, got %0d/%0d %0d %0d",
						$time, e.first, e.second, e.corr, e.count, pair_first, pair_second,
						correlation, used_samples);
					errors++;
				end
			end
		end
	end

	stim_row_t directed[] = '{
		'{65536, 0, 65536, 0, 7, 9, 1, EXP_NONE, 0},
		'{65536, 0, 65536, 0, 0, 65535, 0, EXP_MODEL, 0},
		'{131072, 0, 131072, 0, 0, 65535, 1, EXP_CORR, ONE_Q30},
		'{65536, 0, 131072, 0, 65535, 0, 0, EXP_MODEL, 0},
		'{131072, 0, 65536, 0, 65535, 0, 1, EXP_CORR, -ONE_Q30},
		'{65536, 1, 65536, 0, 1, 2, 0, EXP_MODEL, 0},
		'{8388607, 0, 65536, 0, 1, 2, 0, EXP_MODEL, 0},
		'{-8388608, 0, 65536, 0, 1, 2, 0, EXP_MODEL, 0},
		'{65536, 0, 65536, 1, 1, 2, 0, EXP_MODEL, 0},
		'{0, 0, 65536, 0, 1, 2, 0, EXP_MODEL, 0},
		'{1310720, 0, 65536, 0, 1, 2, 0, EXP_MODEL, 0},
		'{65536, 0, 65536, 0, 1, 2, 1, EXP_NONE, 0},
		'{100, 0, 100, 0, 3, 4, 0, EXP_MODEL, 0},
		'{100, 0, 200, 0, 3, 4, 1, EXP_NONE, 0},
		'{65536, 0, 70000, 0, 5, 6, 0, EXP_MODEL, 0},
		'{200000, 0, 150000, 0, 5, 6, 0, EXP_MODEL, 0},
		'{300000, 0, 400000, 0, 5, 6, 0, EXP_MODEL, 0},
		'{1310719, 0, 1, 0, 5, 6, 1, EXP_MODEL, 0},
		'{1, 0, -8388608, 0, 8, 8, 0, EXP_MODEL, 0},
		'{1, 0, 8388607, 0, 8, 8, 1, EXP_NONE, 0}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		x_value <= '0;
		x_missing <= 1'b0;
		y_value <= '0;
		y_missing <= 1'b0;
		row_a <= '0;
		row_b <= '0;
		last <= 1'b0;
		lim_lo = 0;
		lim_hi = 1310720;
		min_count = 30;
		n_pairs = 0;
		s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_pair(directed[0]);
		write_limits(0, 1310720, 2);
		for (int i = 1; i < directed.size(); i++) send_pair(directed[i]);

		write_limits(0, 1310720, 30);
		for (int i = 0; i < 20; i++) send_row($urandom_range(30, 60), 10);
		write_limits(-8388608, 8388607, 2);
		for (int i = 0; i < 15; i++) send_row($urandom_range(2, 12), 10);
		write_limits(-655360, 655360, 10);
		for (int i = 0; i < 12; i++) send_row($urandom_range(10, 30), 15);
		write_limits(-8388608, 8388607, 4096);
		for (int i = 0; i < 3; i++) send_row(20, 5);
		write_limits(-8388608, 8388607, 0);
		for (int i = 0; i < 10; i++) send_row($urandom_range(1, 8), 30);
		write_limits(0, 1310720, 30);
		for (int i = 0; i < 14; i++) send_row($urandom_range(30, 50), 10);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (3200) @(posedge clk);
		$display("Sent %0d sample pairs over seven limit settings; checked %0d correlations.",
			items_sent, results_seen);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#100000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

[masked_pearson_correlation_unit.f]
hw/rtl/mpc_pkg.sv
hw/rtl/mpc_fifo.sv
hw/rtl/mpc_front.sv
hw/rtl/mpc_mul.sv
hw/rtl/mpc_back.sv
hw/rtl/masked_pearson_correlation_unit.sv
test/testbench.sv
